FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 compression core
// ----------------------------------------------------------------------------
package sha_pkg;

  // rounds per block and the width of the round counter
  localparam int ROUNDS     = 64;
  localparam int RC_W       = $clog2(ROUNDS);
  // eight chaining words, a to h
  localparam int HASH_WORDS = 8;
  localparam int IDX_W      = $clog2(HASH_WORDS);
  localparam int WORD_W     = 32;
  // stream payload widths, padded to whole bytes
  localparam int TDATA_W    = ((IDX_W + WORD_W + 7) / 8) * 8;

  // tuser codes on the input side
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ROUND = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  // index 0 is word a, index 7 is word h
  typedef word_t [HASH_WORDS-1:0] vars_t;
  typedef logic [RC_W-1:0]    round_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // rotate right by a constant amount
  function automatic word_t rotr(input word_t v, input int amt);
    return (v >> amt) | (v << (WORD_W - amt));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // round constants
  function automatic word_t round_k(input round_t t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 round: combinational update of the eight working variables
// ----------------------------------------------------------------------------
module sha_round
  import sha_pkg::*;
(
  input  vars_t v,
  input  word_t k,
  input  word_t w,
  output vars_t v_next
);

  word_t t1;
  word_t t2;

  // the two temporaries of the round
  assign t1 = v[7] + big_sigma1(v[4]) + choose(v[4], v[5], v[6]) + k + w;
  assign t2 = big_sigma0(v[0]) + majority(v[0], v[1], v[2]);

  // shift the variables down and insert the new a and e
  always_comb begin
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

endmodule

FILE: rtl/sha_out_buf.sv
// ----------------------------------------------------------------------------
// sha_out_buf
// Holds the eight updated chaining words and sends them out one per transaction
// ----------------------------------------------------------------------------
module sha_out_buf
  import sha_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  vars_t              load_words,
  output logic               busy,
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata fields from bit 0: hash_index (3), hash_word (32), zero fill
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);

  localparam int PAD_W = TDATA_W - IDX_W - WORD_W;

  vars_t hbuf;
  idx_t  cnt;

  // drain counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && m_tready) begin
      cnt <= cnt + idx_t'(1);
      if (cnt == idx_t'(HASH_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (load) begin
      hbuf <= load_words;
    end
  end

  // output transaction
  assign m_tvalid = busy;
  assign m_tlast  = (cnt == idx_t'(HASH_WORDS - 1));
  assign m_tdata  = {{PAD_W{1'b0}}, hbuf[cnt], cnt};

endmodule

FILE: rtl/sha256_compression.sv
// ----------------------------------------------------------------------------
// sha256_compression
// SHA-256 compression function, one round per schedule-word transaction
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; after the final round of a block the
//   input stalls for the block addition, and a final round waits
//   while the previous block's words are still leaving.
// Output: the first hash word is valid once the fold flag and then busy are set
//   after the final round; the eight words then leave one per output transaction.
// Reset: synchronous; round and chaining state clear and the output buffer is empty.
module sha256_compression
  import sha_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // s_tdata fields from bit 0: word_index (3), data_word (32), zero fill
  input  logic [TDATA_W-1:0] s_tdata,
  // s_tuser fields from bit 0: cmd (1)
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata fields from bit 0: hash_index (3), hash_word (32), zero fill
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);

  localparam round_t LAST_ROUND = round_t'(ROUNDS - 1);

  vars_t  cv;
  vars_t  wv;
  vars_t  round_in;
  vars_t  round_out;
  vars_t  cv_sum;
  round_t round_count;
  logic   fold;
  logic   buf_busy;
  logic   in_acc;
  logic   is_round;
  logic   final_round;
  idx_t   word_index;
  word_t  data_word;

  // input transaction decode
  assign in_acc      = s_tvalid && s_tready;
  assign is_round    = in_acc && (s_tuser == CMD_ROUND);
  assign final_round = (round_count == LAST_ROUND);
  assign word_index  = s_tdata[IDX_W-1:0];
  assign data_word   = s_tdata[IDX_W+WORD_W-1:IDX_W];

  // hold off during the fold cycle, and the final round while words still drain
  assign s_tready = !fold && !(buf_busy && final_round);

  // round 0 starts from the chaining value
  assign round_in = (round_count == '0) ? cv : wv;

  sha_round u_round (
    .v      (round_in),
    .k      (round_k(round_count)),
    .w      (data_word),
    .v_next (round_out)
  );

  // block addition into the chaining value
  always_comb begin
    for (int i = 0; i < HASH_WORDS; i++) begin
      cv_sum[i] = cv[i] + wv[i];
    end
  end

  // round state
  always_ff @(posedge clk) begin
    if (rst) begin
      wv          <= '0;
      round_count <= '0;
      fold        <= 1'b0;
    end else begin
      fold <= is_round && final_round;
      if (is_round) begin
        wv          <= round_out;
        round_count <= final_round ? '0 : round_count + round_t'(1);
      end
    end
  end

  // chaining value: folded after a block, loaded word by word between blocks
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (fold) begin
      cv <= cv_sum;
    end else if (in_acc && (s_tuser == CMD_LOAD) && (round_count == '0)) begin
      cv[word_index] <= data_word;
    end
  end

  sha_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (fold),
    .load_words (cv_sum),
    .busy       (buf_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // no input transaction in the fold cycle
  a_no_accept_in_fold: assert property (@(posedge clk) disable iff (rst)
    fold |-> !in_acc)
    else $error("input taken during fold cycle");

  // fold follows the final round and leaves the counter at zero
  a_fold_after_final: assert property (@(posedge clk) disable iff (rst)
    fold |-> (round_count == '0) && !buf_busy)
    else $error("fold with bad round count or busy buffer");

  // the last word empties the buffer
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output still valid after last word");

  // a final round is never taken while words are still draining
  a_final_waits: assert property (@(posedge clk) disable iff (rst)
    (is_round && final_round) |-> !buf_busy)
    else $error("final round taken while buffer busy");

endmodule
